// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: rtl/swl_pkg.sv
// Constants and types for the sliding window lane search.
package swl_pkg;
   localparam int IMG_WIDTH   = 640;
   localparam int IMG_HEIGHT  = 480;
   localparam int MAX_POINTS  = 60;
   localparam int X_W         = 10;
   localparam int Y_W         = 9;
   localparam int CFG_W       = 9;
   localparam int STORE_DEPTH = IMG_WIDTH * IMG_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W       = $clog2(STORE_DEPTH * (IMG_WIDTH - 1) + 1);
   localparam int N_W         = $clog2(MAX_POINTS);
   localparam int STEP_W      = $clog2(X_W);

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   localparam logic CSR_WINDOW_WIDTH  = 1'b0;
   localparam logic CSR_WINDOW_HEIGHT = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage

// File: rtl/sliding_window_lane_search.sv
// Sliding window lane search over a binary image held in a one-bit pixel store.
//
// req channel: tuser selects the word kind (0 load one pixel, 1 start a search).
// A load writes one bit of the store; loads stream one per cycle while no
// search runs. Every pixel a search touches must have been loaded first.
// A search walks windows from its start row upward and returns one rsp word
// per window (tlast on the topmost one, at most 60 words). Each window runs
// through a setup step, a scan of one pixel per cycle from the single read
// port, a drain step, the divider (start, 10-bit quotient, done) for the
// column mean and an emit step. req_tready is low for the whole search. csr
// writes (window width, height) are taken in any cycle and apply to the next
// search.
// rsp has one output register: the next window is scanned while a word waits;
// a stalled receiver holds the search only when the next word is ready.
// Reset restores width 60 and height 40 and idles both channels; the pixel
// store is not cleared and needs no clearing pass.
`include "assert_macros.svh"
module sliding_window_lane_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pixel_x, pixel_y, pixel_on, start_x, start_y, zero pad
   input  logic [39:0]               req_tdata,
   // func
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // point_x, point_y, zero pad
   output logic [23:0]               rsp_tdata,
   output logic                      rsp_tlast,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [swl_pkg::CFG_W-1:0] csr_data
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DIVGO = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   localparam int XW = swl_pkg::X_W;
   localparam int YW = swl_pkg::Y_W;
   localparam int CW = swl_pkg::CFG_W;
   localparam int AW = swl_pkg::ADDR_W;

   logic [XW-1:0] in_pixel_x, in_start_x;
   logic [YW-1:0] in_pixel_y, in_start_y;
   logic          in_pixel_on;

   assign in_pixel_x  = req_tdata[9:0];
   assign in_pixel_y  = req_tdata[18:10];
   assign in_pixel_on = req_tdata[19];
   assign in_start_x  = req_tdata[29:20];
   assign in_start_y  = req_tdata[38:30];

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cfg_w_ff, cfg_h_ff;
   logic [CW-1:0] w_ff, w_in, h_ff, h_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [swl_pkg::N_W-1:0] n_ff, n_in;
   logic [AW-1:0] row_addr_ff, row_addr_in;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [swl_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [swl_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic          rd_vld_ff;
   logic          rd_bit_ff;
   logic [XW-1:0] rd_col_ff;
   logic [AW-1:0] rd_addr;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0] rsp_x_ff, rsp_x_in;
   logic [YW-1:0] rsp_y_ff, rsp_y_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          div_start;
   swl_pkg::div_stat_type div_stat;
   logic [XW-1:0] div_q;

   logic          req_acc, load_we;
   logic [AW-1:0] wr_addr;

   logic mem [swl_pkg::STORE_DEPTH];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign load_we    = req_acc && (req_tuser == swl_pkg::FUNC_LOAD)
                       && (32'(in_pixel_x) < swl_pkg::IMG_WIDTH)
                       && (32'(in_pixel_y) < swl_pkg::IMG_HEIGHT);
   assign wr_addr    = AW'(in_pixel_y * AW'(swl_pkg::IMG_WIDTH)) + AW'(in_pixel_x);
   assign rd_addr    = row_addr_ff + AW'(col_ff);

   always_ff @(posedge clock) begin
      if (load_we) begin
         mem[wr_addr] <= in_pixel_on;
      end
      rd_bit_ff <= mem[rd_addr];
   end

   swl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   logic [XW:0]   wc_ext;
   logic [CW-1:0] w_clamp, h_clamp;
   logic [XW:0]   sx_sum;
   logic [XW-1:0] ptx;
   logic          last_v, slot_free;
   logic [CW:0]   half_up;
   logic [XW:0]   nx;

   always_comb begin
      wc_ext  = (XW+1)'(cfg_w_ff);
      w_clamp = cfg_w_ff;
      if (cfg_w_ff == '0) begin
         w_clamp = CW'(1);
      end else if (wc_ext > (XW+1)'(swl_pkg::IMG_WIDTH - 1)) begin
         w_clamp = CW'(swl_pkg::IMG_WIDTH - 1);
      end
      h_clamp = cfg_h_ff;
      if (cfg_h_ff == '0) begin
         h_clamp = CW'(1);
      end else if (32'(cfg_h_ff) > swl_pkg::IMG_HEIGHT) begin
         h_clamp = CW'(swl_pkg::IMG_HEIGHT);
      end
      sx_sum    = (XW+1)'(in_start_x) + (XW+1)'(w_clamp);
      slot_free = !rsp_valid_ff || rsp_tready;
      ptx       = (cnt_ff != '0) ? div_q : x_ff + XW'(w_ff >> 1);
      last_v    = (YW'(h_ff) > y_ff) || (32'(n_ff) == swl_pkg::MAX_POINTS - 1);
      half_up   = ((CW+1)'(w_ff) + 1'b1) >> 1;
      nx        = ((XW+1)'(ptx) < (XW+1)'(half_up)) ? '0
                  : (XW+1)'(ptx) - (XW+1)'(half_up);
      if (32'(nx) + 32'(w_ff) >= swl_pkg::IMG_WIDTH) begin
         nx = (XW+1)'(swl_pkg::IMG_WIDTH - 1) - (XW+1)'(w_ff);
      end

      state_in     = state_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      n_in         = n_ff;
      row_addr_in  = row_addr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      div_start    = 1'b0;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (rd_vld_ff && rd_bit_ff) begin
         sum_in = sum_ff + swl_pkg::SUM_W'(rd_col_ff);
         cnt_in = cnt_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == swl_pkg::FUNC_SEARCH)) begin
               w_in = w_clamp;
               h_in = h_clamp;
               x_in = in_start_x;
               if (32'(sx_sum) >= swl_pkg::IMG_WIDTH) begin
                  x_in = XW'(swl_pkg::IMG_WIDTH - 1) - XW'(w_clamp);
               end
               y_in = in_start_y;
               if (32'(in_start_y) > swl_pkg::IMG_HEIGHT - 32'(h_clamp)) begin
                  y_in = YW'(swl_pkg::IMG_HEIGHT) - YW'(h_clamp);
               end
               n_in     = '0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            row_addr_in = AW'(y_ff * AW'(swl_pkg::IMG_WIDTH)) + AW'(x_ff);
            col_in      = '0;
            row_in      = '0;
            sum_in      = '0;
            cnt_in      = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (col_ff == w_ff - 1'b1) begin
               col_in = '0;
               if (row_ff == h_ff - 1'b1) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in      = row_ff + 1'b1;
                  row_addr_in = row_addr_ff + AW'(swl_pkg::IMG_WIDTH);
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_DIVGO;
         ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = ptx;
               rsp_y_in     = y_ff + YW'(h_ff >> 1);
               rsp_last_in  = last_v;
               y_in         = (YW'(h_ff) > y_ff) ? '0 : y_ff - YW'(h_ff);
               x_in         = XW'(nx);
               n_in         = n_ff + 1'b1;
               state_in     = last_v ? ST_IDLE : ST_SETUP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_w_ff     <= CW'(60);
         cfg_h_ff     <= CW'(40);
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= (state_ff == ST_SCAN);
         n_ff         <= n_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == swl_pkg::CSR_WINDOW_WIDTH) begin
               cfg_w_ff <= csr_data;
            end else begin
               cfg_h_ff <= csr_data;
            end
         end
      end
      w_ff        <= w_in;
      h_ff        <= h_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      row_addr_ff <= row_addr_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      rd_col_ff   <= x_ff + XW'(col_ff);
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_NEVER(a_rd_outside_scan,
      rd_vld_ff && !(state_ff == ST_SCAN || state_ff == ST_DRAIN))
   `ASSERT_NEVER(a_div_done_state, div_stat.done && state_ff != ST_DIV)
   `ASSERT_NEVER(a_point_cap, 32'(n_ff) > swl_pkg::MAX_POINTS)
endmodule

// File: rtl/swl_div.sv
// Restoring divider, one quotient bit per cycle, for the column mean.
`include "assert_macros.svh"
module swl_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [swl_pkg::SUM_W-1:0]   dividend,
   input  logic [swl_pkg::CNT_W-1:0]   divisor,
   output swl_pkg::div_stat_type       stat,
   output logic [swl_pkg::X_W-1:0]     quotient
);
   localparam int TW = swl_pkg::SUM_W + swl_pkg::X_W;

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [swl_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [swl_pkg::SUM_W-1:0]    rem_ff, rem_in;
   logic [swl_pkg::X_W-1:0]      q_ff, q_in;
   logic [TW-1:0]                trial;

   assign trial = TW'(divisor) << step_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = swl_pkg::STEP_W'(swl_pkg::X_W - 1);
         rem_in  = dividend;
         q_in    = '0;
      end else if (busy_ff) begin
         if (TW'(rem_ff) >= trial) begin
            rem_in        = rem_ff - swl_pkg::SUM_W'(trial);
            q_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

   `ASSERT_CLK(a_done_pulse, done_ff |=> !done_ff)
   `ASSERT_NEVER(a_start_busy, start && busy_ff)
   `ASSERT_CLK(a_start_runs, start |=> busy_ff)
endmodule
